// File: rtl/core/jpid_pkg.sv
// ----------------------------------------------------------------------------
// jpid_pkg
// shared types and constants for the joint pid servo command block
// ----------------------------------------------------------------------------
package jpid_pkg;

    localparam int JOINTS_DEFAULT = 6;

    localparam int JOINT_W    = 3;
    localparam int POS_W      = 12;
    localparam int ERR_W      = 13;
    localparam int GAIN_W     = 16;
    localparam int KNEE_W     = 12;
    localparam int LIMIT_W    = 12;
    localparam int INTEG_W    = 21;
    localparam int DRIVE_W    = 11;
    localparam int MAG_W      = 10;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [LIMIT_W-1:0] INTEGRAL_LIMIT_RESET = 12'd800;
    localparam logic [MAG_W-1:0]   DRIVE_LIMIT          = 10'd800;
    localparam int                 STICTION_Q8          = 60 * 256;

    localparam logic [CFG_IDX_W-1:0] REG_ENABLE         = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KP_GAIN        = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KP_OUTER_GAIN  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_KNEE_ERROR     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_KI_GAIN        = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_INTEGRAL_LIMIT = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_KD_GAIN        = 3'd6;

    typedef struct packed {
        logic [JOINT_W-1:0] joint;
        logic [POS_W-1:0]   measured_position;
        logic [POS_W-1:0]   goal_position;
    } in_word_t;

    typedef struct packed {
        logic [JOINT_W-1:0] joint_out;
        logic [DRIVE_W-1:0] drive_command;
        logic               saturated;
    } out_word_t;

    typedef struct packed {
        logic               enable;
        logic [GAIN_W-1:0]  kp_gain;
        logic [GAIN_W-1:0]  kp_outer_gain;
        logic [KNEE_W-1:0]  knee_error;
        logic [GAIN_W-1:0]  ki_gain;
        logic [LIMIT_W-1:0] integral_limit;
        logic [GAIN_W-1:0]  kd_gain;
    } cfg_t;

endpackage

// File: rtl/core/jpid_calc.sv
// ----------------------------------------------------------------------------
// jpid_calc
// single-pass pid datapath: dual-slope p, clamped i, error-difference d,
// stiction offset, negation, truncation, saturation and sign-magnitude coding
// ----------------------------------------------------------------------------
module jpid_calc
(
    input  jpid_pkg::cfg_t                          cfg,
    input  logic signed [jpid_pkg::ERR_W-1:0]       err,
    input  logic signed [jpid_pkg::INTEG_W-1:0]     integ,
    input  logic signed [jpid_pkg::ERR_W-1:0]       prev_err,
    input  logic                                    stic_neg,
    output logic signed [jpid_pkg::INTEG_W-1:0]     integ_next,
    output logic [jpid_pkg::DRIVE_W-1:0]            drive_command,
    output logic                                    saturated
);
    import jpid_pkg::*;

    localparam int EW = 14;
    localparam int PW = 31;
    localparam int IW = 32;
    localparam int SW = 34;
    localparam logic signed [SW-1:0] STIC_POS = SW'(STICTION_Q8);

    logic signed [EW-1:0] err_x;
    logic signed [EW-1:0] knee_x;
    logic signed [EW-1:0] excess;
    logic signed [EW-1:0] derr;
    logic signed [16:0]   kp_s;
    logic signed [16:0]   kpo_diff;
    logic signed [16:0]   ki_s;
    logic signed [16:0]   kd_s;
    logic signed [PW-1:0] p_inner;
    logic signed [PW-1:0] p_outer;
    logic signed [PW-1:0] p_int;
    logic signed [PW-1:0] p_der;
    logic signed [IW-1:0] lim;
    logic signed [IW-1:0] iacc;
    logic signed [IW-1:0] iacc_c;
    logic signed [SW-1:0] stic;
    logic signed [SW-1:0] sum;
    logic                 negative;
    logic [SW-1:0]        abs_val;
    logic [SW-1:0]        mag_full;
    logic [MAG_W-1:0]     mag;

    // dual-slope proportional
    always_comb
    begin
        err_x  = {err[ERR_W-1], err};
        knee_x = EW'($signed({2'b00, cfg.knee_error}));
        if (err_x > knee_x)
        begin
            excess = err_x - knee_x;
        end
        else if (err_x < -knee_x)
        begin
            excess = err_x + knee_x;
        end
        else
        begin
            excess = '0;
        end
    end

    assign kp_s     = $signed({1'b0, cfg.kp_gain});
    assign kpo_diff = $signed({1'b0, cfg.kp_outer_gain}) - kp_s;
    assign ki_s     = $signed({1'b0, cfg.ki_gain});
    assign kd_s     = $signed({1'b0, cfg.kd_gain});
    assign derr     = err_x - {prev_err[ERR_W-1], prev_err};

    assign p_inner = PW'(kp_s) * PW'(err_x);
    assign p_outer = PW'(kpo_diff) * PW'(excess);
    assign p_int   = PW'(ki_s) * PW'(err_x);
    assign p_der   = PW'(kd_s) * PW'(derr);

    // integrator with symmetric clamp
    assign lim  = $signed(IW'({cfg.integral_limit, 8'h00}));
    assign iacc = IW'(integ) + IW'(p_int);

    always_comb
    begin
        priority if (iacc > lim)
        begin
            iacc_c = lim;
        end
        else if (iacc < -lim)
        begin
            iacc_c = -lim;
        end
        else
        begin
            iacc_c = iacc;
        end
    end

    assign integ_next = INTEG_W'(iacc_c);

    // command is the negated sum, truncated toward zero
    assign stic     = stic_neg ? -STIC_POS : STIC_POS;
    assign sum      = SW'(p_inner) + SW'(p_outer) + SW'(iacc_c) + SW'(p_der) + stic;
    assign negative = (sum > 0);
    assign abs_val  = negative ? SW'(sum) : SW'(-sum);
    assign mag_full = abs_val >> 8;
    assign saturated = (mag_full > SW'(DRIVE_LIMIT));
    assign mag       = saturated ? DRIVE_LIMIT : mag_full[MAG_W-1:0];

    assign drive_command = {negative && (mag != '0), mag};

endmodule

// File: rtl/core/joint_pid_dual_slope_servo_command.sv
// ----------------------------------------------------------------------------
// joint_pid_dual_slope_servo_command
// per-joint pid servo command with dual-slope p, clamped i and stiction
// ----------------------------------------------------------------------------
// usage:
//   in channel carries one joint sample word (joint, measured and goal
//   position); out channel returns one command word per sample while enabled
//   and the joint index is in range, otherwise the sample is dropped.
//   cfg channel writes the seven control registers by index and is always
//   ready; the user must write it only while no sample is in flight, which
//   the block does not enforce. path: an accepted word is held in the input
//   register, and its command is loaded into the result register when that
//   register is empty or its word is being taken.
//   throughput: one word per cycle when not stalled; the per-joint integrator
//   and last error are read and written in the same cycle as the result
//   register load, so back-to-back samples of one joint see up-to-date state.
//   stall: while out_stall holds a full result register, the input register
//   keeps any word, and if it holds one in_stall rises in the same cycle.
//   reset clears both valid flags, integrators, last errors and stiction sign;
//   integral_limit resets to 800, everything else to 0 (block disabled).
// ----------------------------------------------------------------------------
module joint_pid_dual_slope_servo_command
#(
    parameter int JOINTS = jpid_pkg::JOINTS_DEFAULT
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  jpid_pkg::in_word_t                  in_word,
    output logic                                out_valid,
    input  logic                                out_stall,
    output jpid_pkg::out_word_t                 out_word,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [jpid_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [jpid_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import jpid_pkg::*;

    localparam int                 JIDX_W      = (JOINTS > 1) ? $clog2(JOINTS) : 1;
    localparam logic [4:0]         JOINT_LIMIT = 5'(JOINTS);

    localparam cfg_t CFG_RESET = '{
        enable:         1'b0,
        kp_gain:        '0,
        kp_outer_gain:  '0,
        knee_error:     '0,
        ki_gain:        '0,
        integral_limit: INTEGRAL_LIMIT_RESET,
        kd_gain:        '0
    };

    cfg_t                           cfg_reg;
    cfg_t                           cfg_next;

    logic                           s1_valid_reg;
    logic                           s1_valid_next;
    logic [JOINT_W-1:0]             s1_joint_reg;
    logic signed [ERR_W-1:0]        s1_err_reg;

    logic                           out_valid_reg;
    out_word_t                      out_word_reg;

    logic signed [INTEG_W-1:0]      integ_reg [JOINTS];
    logic signed [ERR_W-1:0]        prev_err_reg [JOINTS];
    logic                           stic_neg_reg;

    logic                           in_accept;
    logic                           take;
    logic                           advance;
    logic                           fire;
    logic [JIDX_W-1:0]              idx;
    logic                           is_j0;
    logic                           stic_used;
    logic signed [ERR_W-1:0]        in_err;
    logic signed [INTEG_W-1:0]      integ_new;
    logic [DRIVE_W-1:0]             drive;
    logic                           sat;

    assign cfg_ready = 1'b1;

    // config registers
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_ENABLE:         cfg_next.enable         = cfg_data[0];
                REG_KP_GAIN:        cfg_next.kp_gain        = cfg_data;
                REG_KP_OUTER_GAIN:  cfg_next.kp_outer_gain  = cfg_data;
                REG_KNEE_ERROR:     cfg_next.knee_error     = cfg_data[KNEE_W-1:0];
                REG_KI_GAIN:        cfg_next.ki_gain        = cfg_data;
                REG_INTEGRAL_LIMIT: cfg_next.integral_limit = cfg_data[LIMIT_W-1:0];
                REG_KD_GAIN:        cfg_next.kd_gain        = cfg_data;
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // handshake
    assign advance   = !out_valid_reg || !out_stall;
    assign in_stall  = s1_valid_reg && !advance;
    assign in_accept = in_valid && !in_stall;
    assign take      = in_accept && cfg_reg.enable
                       && ({2'b00, in_word.joint} < JOINT_LIMIT);
    assign fire      = s1_valid_reg && advance;

    assign in_err = $signed({1'b0, in_word.goal_position})
                  - $signed({1'b0, in_word.measured_position});

    always_comb
    begin
        priority if (in_accept)
        begin
            s1_valid_next = take;
        end
        else if (advance)
        begin
            s1_valid_next = 1'b0;
        end
        else
        begin
            s1_valid_next = s1_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_joint_reg <= in_word.joint;
            s1_err_reg   <= in_err;
        end
    end

    // per-joint state
    assign idx       = JIDX_W'(s1_joint_reg);
    assign is_j0     = (s1_joint_reg == '0);
    assign stic_used = stic_neg_reg ^ is_j0;

    jpid_calc u_calc
    (
        .cfg           (cfg_reg),
        .err           (s1_err_reg),
        .integ         (integ_reg[idx]),
        .prev_err      (prev_err_reg[idx]),
        .stic_neg      (stic_used),
        .integ_next    (integ_new),
        .drive_command (drive),
        .saturated     (sat)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < JOINTS; i++)
            begin
                integ_reg[i]    <= '0;
                prev_err_reg[i] <= '0;
            end
            stic_neg_reg <= 1'b0;
        end
        else if (fire)
        begin
            integ_reg[idx]    <= integ_new;
            prev_err_reg[idx] <= s1_err_reg;
            stic_neg_reg      <= stic_used;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            out_word_reg.joint_out     <= s1_joint_reg;
            out_word_reg.drive_command <= drive;
            out_word_reg.saturated     <= sat;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

endmodule

// File: tb/tb_joint_pid_dual_slope_servo_command.sv
// ----------------------------------------------------------------------------
// tb_joint_pid_dual_slope_servo_command
// self-checking bench for the per-joint pid servo command block
// ----------------------------------------------------------------------------
// a queue of joint samples feeds a clocked driver; a clocked monitor predicts
// the command word of each accepted sample from its own copy of the register
// file, integrators, last errors and stiction sign, and checks every command
// word against the oldest prediction. directed samples cover zero and full
// scale errors, both sides of the knee, joints out of range, the disabled
// block, the stiction flip and commands that truncate to zero; random phases
// then run mostly whole control ticks under several register settings and
// idle/stall mixes.
// ----------------------------------------------------------------------------
module tb_joint_pid_dual_slope_servo_command;

    import jpid_pkg::*;

    localparam int JOINTS      = JOINTS_DEFAULT;
    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASE_WORDS = 125;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    in_word_t    in_word = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    out_word_t   out_word;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    in_word_t  pending_samples[$];
    out_word_t expected_cmds[$];

    cfg_t    servo_cfg;
    longint  integ_acc[JOINTS];
    longint  prev_error[JOINTS];
    bit      stiction_neg;

    bit      in_fired;
    bit      cfg_fired;
    int      send_idle_pct;
    int      stall_pct;
    int      mismatch_count;
    int      cycle_count;

    joint_pid_dual_slope_servo_command #(.JOINTS(JOINTS)) u_top
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_word   (in_word),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_word  (out_word),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #10 clk = ~clk;

    function automatic bit predict_drive(input in_word_t w, output out_word_t cmd);
        int     j;
        longint err;
        longint knee;
        longint excess;
        longint pterm;
        longint lim;
        longint iacc;
        longint dterm;
        longint stic;
        longint total;
        longint neg;
        longint mag;
        bit     neg_cmd;
        bit     sat;
        j = int'(w.joint);
        cmd = '0;
        if (!servo_cfg.enable || j >= JOINTS)
            return 1'b0;
        if (j == 0)
            stiction_neg = ~stiction_neg;
        err = longint'(w.goal_position) - longint'(w.measured_position);
        knee = longint'(servo_cfg.knee_error);
        excess = 0;
        if (err > knee)
            excess = err - knee;
        else if (err < -knee)
            excess = err + knee;
        pterm = longint'(servo_cfg.kp_gain) * err
              + (longint'(servo_cfg.kp_outer_gain) - longint'(servo_cfg.kp_gain)) * excess;
        lim = longint'(servo_cfg.integral_limit) * 256;
        iacc = integ_acc[j] + longint'(servo_cfg.ki_gain) * err;
        if (iacc > lim)
            iacc = lim;
        if (iacc < -lim)
            iacc = -lim;
        integ_acc[j] = iacc;
        dterm = longint'(servo_cfg.kd_gain) * (err - prev_error[j]);
        prev_error[j] = err;
        stic = stiction_neg ? -longint'(STICTION_Q8) : longint'(STICTION_Q8);
        total = stic + pterm + iacc + dterm;
        neg = -total;
        neg_cmd = neg < 0;
        mag = (neg_cmd ? -neg : neg) / 256;
        sat = mag > longint'(DRIVE_LIMIT);
        if (sat)
            mag = longint'(DRIVE_LIMIT);
        if (mag == 0)
            neg_cmd = 1'b0;
        cmd.joint_out = w.joint;
        cmd.drive_command = {neg_cmd, mag[MAG_W-1:0]};
        cmd.saturated = sat;
        return 1'b1;
    endfunction

    function automatic cfg_t make_cfg(input bit en, input int kp, input int kpo,
                                      input int knee, input int ki, input int lim,
                                      input int kd);
        cfg_t s;
        s.enable = en;
        s.kp_gain = kp[GAIN_W-1:0];
        s.kp_outer_gain = kpo[GAIN_W-1:0];
        s.knee_error = knee[KNEE_W-1:0];
        s.ki_gain = ki[GAIN_W-1:0];
        s.integral_limit = lim[LIMIT_W-1:0];
        s.kd_gain = kd[GAIN_W-1:0];
        return s;
    endfunction

    function automatic int pick_gain();
        int r;
        r = $urandom_range(5);
        case (r)
            0: return 0;
            1: return 65535;
            2, 3: return $urandom_range(512);
            default: return $urandom_range(65535);
        endcase
    endfunction

    // called at a falling edge, returns at the falling edge after the write
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(negedge clk); while (!cfg_fired);
        case (idx)
            REG_ENABLE:         servo_cfg.enable = data[0];
            REG_KP_GAIN:        servo_cfg.kp_gain = data;
            REG_KP_OUTER_GAIN:  servo_cfg.kp_outer_gain = data;
            REG_KNEE_ERROR:     servo_cfg.knee_error = data[KNEE_W-1:0];
            REG_KI_GAIN:        servo_cfg.ki_gain = data;
            REG_INTEGRAL_LIMIT: servo_cfg.integral_limit = data[LIMIT_W-1:0];
            REG_KD_GAIN:        servo_cfg.kd_gain = data;
            default: ;
        endcase
    endtask

    task automatic apply_settings(input cfg_t s);
        write_reg(REG_ENABLE, CFG_DATA_W'(s.enable));
        write_reg(REG_KP_GAIN, s.kp_gain);
        write_reg(REG_KP_OUTER_GAIN, s.kp_outer_gain);
        write_reg(REG_KNEE_ERROR, CFG_DATA_W'(s.knee_error));
        write_reg(REG_KI_GAIN, s.ki_gain);
        write_reg(REG_INTEGRAL_LIMIT, CFG_DATA_W'(s.integral_limit));
        write_reg(REG_KD_GAIN, s.kd_gain);
        cfg_valid <= 1'b0;
    endtask

    task automatic queue_sample(input int j, input int pos, input int goal);
        in_word_t w;
        w.joint = j[JOINT_W-1:0];
        w.measured_position = pos[POS_W-1:0];
        w.goal_position = goal[POS_W-1:0];
        pending_samples.push_back(w);
    endtask

    // hold off until every word is out, then let the pipeline drain
    task automatic settle();
        while (pending_samples.size() != 0 || expected_cmds.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic queue_random_phase(input int count);
        int next_joint;
        int j;
        int pos;
        int goal;
        int off;
        next_joint = 0;
        for (int n = 0; n < count; n++)
        begin
            if ($urandom_range(99) < 85)
            begin
                j = next_joint;
                next_joint = (next_joint + 1) % JOINTS;
            end
            else
                j = $urandom_range(7);
            pos = $urandom_range(4095);
            if ($urandom_range(9) < 7)
            begin
                off = $urandom_range(160);
                goal = pos + off - 80;
                if (goal < 0)
                    goal = 0;
                if (goal > 4095)
                    goal = 4095;
            end
            else
                goal = $urandom_range(4095);
            queue_sample(j, pos, goal);
        end
    endtask

    // sample driver
    always @(negedge clk)
    begin
        if (in_valid && in_fired)
            pending_samples.delete(0);
        if (!in_valid || in_fired)
        begin
            if (pending_samples.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                in_valid <= 1'b1;
                in_word <= pending_samples[0];
            end
            else
                in_valid <= 1'b0;
        end
        out_stall <= ($urandom_range(99) < stall_pct);
    end

    // prediction and command check
    always @(posedge clk)
    begin
        out_word_t cmd;
        out_word_t want;
        cycle_count++;
        cfg_fired = cfg_valid && cfg_ready;
        in_fired = in_valid && !in_stall;
        if (in_fired && predict_drive(in_word, cmd))
            expected_cmds.push_back(cmd);
        if (out_valid && !out_stall)
        begin
            if (expected_cmds.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected command word: joint %0d drive %0h sat %0b",
                             out_word.joint_out, out_word.drive_command, out_word.saturated);
            end
            else
            begin
                want = expected_cmds.pop_front();
                if (out_word.joint_out !== want.joint_out
                    || out_word.drive_command !== want.drive_command
                    || out_word.saturated !== want.saturated)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("command mismatch: joint %0d/%0d drive %0h/%0h sat %0b/%0b",
                                 want.joint_out, out_word.joint_out,
                                 want.drive_command, out_word.drive_command,
                                 want.saturated, out_word.saturated);
                end
            end
        end
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("joint_pid_dual_slope_servo_command test failed");
            $finish;
        end
    end

    initial
    begin
        servo_cfg = '0;
        servo_cfg.integral_limit = INTEGRAL_LIMIT_RESET;
        foreach (integ_acc[i])
        begin
            integ_acc[i] = 0;
            prev_error[i] = 0;
        end
        stiction_neg = 1'b0;
        send_idle_pct = 0;
        stall_pct = 0;
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // zero error, stiction flip, full scale, both sides of the knee
        apply_settings(make_cfg(1'b1, 16'h0100, 16'h0080, 100, 16'h0010, 800, 16'h0040));
        queue_sample(0, 2048, 2048);
        queue_sample(1, 2048, 2048);
        queue_sample(0, 2048, 2048);
        queue_sample(1, 0, 4095);
        queue_sample(2, 4095, 0);
        queue_sample(3, 2048, 2108);
        queue_sample(3, 2048, 2248);
        queue_sample(4, 2048, 1848);
        queue_sample(5, 0, 0);
        queue_sample(5, 4095, 4095);
        queue_sample(6, 100, 200);
        queue_sample(7, 4095, 4095);
        settle();

        // disabled block drops words and keeps its state
        apply_settings(make_cfg(1'b0, 16'h0100, 16'h0080, 100, 16'h0010, 800, 16'h0040));
        queue_sample(0, 1000, 3000);
        queue_sample(1, 3000, 1000);
        settle();

        // commands that truncate to zero around the stiction offset
        apply_settings(make_cfg(1'b1, 16'h00FF, 16'h00FF, 0, 0, 800, 0));
        queue_sample(1, 2108, 2048);
        queue_sample(1, 2048, 2108);
        queue_sample(0, 2048, 2048);
        queue_sample(1, 2108, 2048);
        queue_sample(1, 2048, 2108);
        settle();

        for (int p = 0; p < 8; p++)
        begin
            case (p)
                0: apply_settings(make_cfg(1'b1, 65535, 65535, 4095, 65535, 4095, 65535));
                1: apply_settings(make_cfg(1'b1, 0, 0, 0, 0, 0, 0));
                default: apply_settings(make_cfg(1'b1, pick_gain(), pick_gain(),
                                                 $urandom_range(4095), pick_gain(),
                                                 $urandom_range(4095), pick_gain()));
            endcase
            case (p % 4)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 74; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 74; end
                default: begin send_idle_pct = 31; stall_pct = 31; end
            endcase
            queue_random_phase(PHASE_WORDS);
            settle();
        end

        repeat (10) @(negedge clk);
        if (mismatch_count == 0)
            $display("joint_pid_dual_slope_servo_command test passed");
        else
            $display("joint_pid_dual_slope_servo_command test failed");
        $finish;
    end

endmodule
